@@ hw/rtl/lntf_pkg.sv @@
// lntf_pkg: shared constants, types and helpers for the line numbering text filter
// depends on nothing; used by every module of the block
`default_nettype none

package lntf_pkg;

   // number column width in decimal digits
   localparam int NUMBER_DIGITS = 6;
   localparam int BCD_W = 4 * NUMBER_DIGITS;
   localparam int DIGIT_IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SQUEEZE_BLANK = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_ENDS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_TABS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_NONPRINTING = 3'd4;

   // number modes
   localparam logic [1:0] NUM_NONE = 2'd0;
   localparam logic [1:0] NUM_ALL = 2'd1;

   // character codes
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_I = 8'h49;
   localparam logic [7:0] CH_M = 8'h4D;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_CTRL_END = 8'h20;
   localparam logic [7:0] CH_CTRL_OFFSET = 8'h40;

   // one classified input byte, as handed from front to back
   typedef struct packed {
      logic [BCD_W-1:0] bcd;
      logic             num_en;
      logic             dollar;
      logic             meta;
      logic             caret;
      logic [7:0]       ch;
   } job_type;

   // back sequencer steps, in emission order
   typedef enum logic [2:0] {
      STEP_DIGIT,
      STEP_NUM_TAB,
      STEP_DOLLAR,
      STEP_META_M,
      STEP_META_DASH,
      STEP_CARET,
      STEP_CHAR
   } step_type;

   // saturating bcd increment; stays at all nines
   function automatic logic [BCD_W-1:0] bcd_inc_sat(input logic [BCD_W-1:0] v);
      logic [BCD_W-1:0] r;
      logic             carry;
      logic             all_nines;
      logic [3:0]       d;
      r = v;
      carry = 1'b1;
      all_nines = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         d = v[4*i +: 4];
         if (d != 4'd9) begin
            all_nines = 1'b0;
         end
         if (carry) begin
            if (d >= 4'd9) begin
               r[4*i +: 4] = 4'd0;
            end else begin
               r[4*i +: 4] = d + 4'd1;
               carry = 1'b0;
            end
         end
      end
      return all_nines ? v : r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lntf_front.sv @@
// lntf_front: accepts input transactions, holds configuration and line state,
// classifies each byte into a job; depends on lntf_pkg
`default_nettype none

module lntf_front (
   input  wire                               clock,
   input  wire                               reset,
   // input channel
   input  wire                               req_push,
   output logic                              req_full,
   input  wire  [7:0]                        req_in_byte,
   input  wire                               req_file_start,
   // configuration port
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [lntf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [lntf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // job queue write side
   output logic                              job_push,
   output lntf_pkg::job_type                 job_data,
   input  wire                               job_full
);

   logic [1:0]                  number_mode_ff, number_mode_in;
   logic                        squeeze_ff, squeeze_in;
   logic                        show_ends_ff, show_ends_in;
   logic                        show_tabs_ff, show_tabs_in;
   logic                        show_np_ff, show_np_in;
   logic                        at_line_start_ff, at_line_start_in;
   logic [1:0]                  newline_run_ff, newline_run_in;
   logic [lntf_pkg::BCD_W-1:0]  bcd_ff, bcd_in;

   logic       accept;
   logic       nl;
   logic       drop;
   logic       als_eff;
   logic [1:0] run_eff;
   logic       numbering;
   logic       num_en;
   logic       tab_caret;
   logic [7:0] c1;
   logic [7:0] c2;
   logic       np;
   logic       np_caret;
   logic [7:0] ch_out;

   assign csr_ready = 1'b1;
   assign req_full  = job_full;
   assign accept    = req_push && !job_full;

   // classification of the incoming byte
   always_comb begin
      nl        = (req_in_byte == lntf_pkg::CH_NEWLINE);
      als_eff   = req_file_start ? 1'b1 : at_line_start_ff;
      run_eff   = req_file_start ? 2'd1 : newline_run_ff;
      drop      = nl && squeeze_ff && (run_eff >= 2'd2);
      numbering = (number_mode_ff == lntf_pkg::NUM_ALL) || (number_mode_ff[1] && !nl);
      num_en    = als_eff && numbering;

      tab_caret = show_tabs_ff && (req_in_byte == lntf_pkg::CH_TAB);
      c1        = tab_caret ? lntf_pkg::CH_I : req_in_byte;
      np        = show_np_ff && (c1 != lntf_pkg::CH_TAB) && (c1 != lntf_pkg::CH_NEWLINE);
      c2        = np ? {1'b0, c1[6:0]} : c1;
      np_caret  = np && ((c2 < lntf_pkg::CH_CTRL_END) || (c2 == lntf_pkg::CH_DEL));
      if (np && (c2 < lntf_pkg::CH_CTRL_END)) begin
         ch_out = c2 + lntf_pkg::CH_CTRL_OFFSET;
      end else if (np && (c2 == lntf_pkg::CH_DEL)) begin
         ch_out = lntf_pkg::CH_QUESTION;
      end else begin
         ch_out = c2;
      end

      job_push        = accept && !drop;
      job_data.bcd    = bcd_ff;
      job_data.num_en = num_en;
      job_data.dollar = show_ends_ff && nl;
      job_data.meta   = np && c1[7];
      job_data.caret  = tab_caret || np_caret;
      job_data.ch     = ch_out;
   end

   // line state update on every transaction that is not dropped
   always_comb begin
      at_line_start_in = at_line_start_ff;
      newline_run_in   = newline_run_ff;
      bcd_in           = bcd_ff;
      if (job_push) begin
         at_line_start_in = nl;
         if (nl) begin
            newline_run_in = (run_eff < 2'd2) ? run_eff + 2'd1 : run_eff;
         end else begin
            newline_run_in = 2'd0;
         end
         if (num_en) begin
            bcd_in = lntf_pkg::bcd_inc_sat(bcd_ff);
         end
      end
   end

   // configuration register writes
   always_comb begin
      number_mode_in = number_mode_ff;
      squeeze_in     = squeeze_ff;
      show_ends_in   = show_ends_ff;
      show_tabs_in   = show_tabs_ff;
      show_np_in     = show_np_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lntf_pkg::CSR_NUMBER_MODE:      number_mode_in = csr_wdata[1:0];
            lntf_pkg::CSR_SQUEEZE_BLANK:    squeeze_in     = csr_wdata[0];
            lntf_pkg::CSR_SHOW_ENDS:        show_ends_in   = csr_wdata[0];
            lntf_pkg::CSR_SHOW_TABS:        show_tabs_in   = csr_wdata[0];
            lntf_pkg::CSR_SHOW_NONPRINTING: show_np_in     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_mode_ff   <= lntf_pkg::NUM_NONE;
         squeeze_ff       <= 1'b0;
         show_ends_ff     <= 1'b0;
         show_tabs_ff     <= 1'b0;
         show_np_ff       <= 1'b0;
         at_line_start_ff <= 1'b1;
         newline_run_ff   <= 2'd1;
         bcd_ff           <= lntf_pkg::BCD_W'(1);
      end else begin
         number_mode_ff   <= number_mode_in;
         squeeze_ff       <= squeeze_in;
         show_ends_ff     <= show_ends_in;
         show_tabs_ff     <= show_tabs_in;
         show_np_ff       <= show_np_in;
         at_line_start_ff <= at_line_start_in;
         newline_run_ff   <= newline_run_in;
         bcd_ff           <= bcd_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/lntf_queue.sv @@
// lntf_queue: short job queue that decouples front and back
// depends on lntf_pkg
`default_nettype none

module lntf_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  wire lntf_pkg::job_type  push_data,
   output logic                    full,
   input  wire                     pop,
   output lntf_pkg::job_type       pop_data,
   output logic                    empty
);

   lntf_pkg::job_type              mem_ff [lntf_pkg::QUEUE_DEPTH];
   logic [lntf_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lntf_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lntf_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                           do_push;
   logic                           do_pop;

   assign full     = (count_ff == lntf_pkg::QCNT_W'(lntf_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/lntf_back.sv @@
// lntf_back: expands each job into output bytes, one per cycle while not stalled,
// into an output register; depends on lntf_pkg
`default_nettype none

module lntf_back (
   input  wire                     clock,
   input  wire                     reset,
   // job queue read side
   input  wire lntf_pkg::job_type  job_data,
   input  wire                     job_empty,
   output logic                    job_pop,
   // result channel
   output logic                    rsp_empty,
   input  wire                     rsp_pop,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_last_of_run
);

   localparam logic [lntf_pkg::DIGIT_IDX_W-1:0] TOP_DIGIT =
      lntf_pkg::DIGIT_IDX_W'(lntf_pkg::NUMBER_DIGITS - 1);

   lntf_pkg::job_type                   cur_ff, cur_in;
   logic                                busy_ff, busy_in;
   lntf_pkg::step_type                  step_ff, step_in;
   logic [lntf_pkg::DIGIT_IDX_W-1:0]    idx_ff, idx_in;
   logic                                lead_ff, lead_in;
   logic                                out_valid_ff, out_valid_in;
   logic [7:0]                          out_byte_ff, out_byte_in;
   logic                                out_last_ff, out_last_in;

   logic       advance;
   logic       finishing;
   logic       load;
   logic [3:0] digit;
   logic       lead_now;
   logic [7:0] cur_byte;

   // first step at or after s that this job needs
   function automatic lntf_pkg::step_type skip(input lntf_pkg::job_type j,
                                               input lntf_pkg::step_type s);
      lntf_pkg::step_type r;
      r = s;
      if (r == lntf_pkg::STEP_DIGIT && !j.num_en) begin
         r = lntf_pkg::STEP_DOLLAR;
      end
      if (r == lntf_pkg::STEP_DOLLAR && !j.dollar) begin
         r = lntf_pkg::STEP_META_M;
      end
      if (r == lntf_pkg::STEP_META_M && !j.meta) begin
         r = lntf_pkg::STEP_CARET;
      end
      if (r == lntf_pkg::STEP_CARET && !j.caret) begin
         r = lntf_pkg::STEP_CHAR;
      end
      return r;
   endfunction

   assign rsp_empty       = !out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

   // byte for the current step
   always_comb begin
      digit = cur_ff.bcd[4*idx_ff +: 4];
      if (digit > 4'd9) begin
         digit = 4'd9;
      end
      lead_now = lead_ff && (digit == 4'd0) && (idx_ff != '0);
      case (step_ff)
         lntf_pkg::STEP_DIGIT:     cur_byte = lead_now ? lntf_pkg::CH_SPACE
                                                       : lntf_pkg::CH_ZERO + {4'd0, digit};
         lntf_pkg::STEP_NUM_TAB:   cur_byte = lntf_pkg::CH_TAB;
         lntf_pkg::STEP_DOLLAR:    cur_byte = lntf_pkg::CH_DOLLAR;
         lntf_pkg::STEP_META_M:    cur_byte = lntf_pkg::CH_M;
         lntf_pkg::STEP_META_DASH: cur_byte = lntf_pkg::CH_DASH;
         lntf_pkg::STEP_CARET:     cur_byte = lntf_pkg::CH_CARET;
         lntf_pkg::STEP_CHAR:      cur_byte = cur_ff.ch;
         default:                  cur_byte = cur_ff.ch;
      endcase
   end

   // sequencer: next step, job load and output register
   always_comb begin
      advance   = busy_ff && (!out_valid_ff || rsp_pop);
      finishing = advance && (step_ff == lntf_pkg::STEP_CHAR);
      load      = (!busy_ff || finishing) && !job_empty;
      job_pop   = load;

      cur_in  = cur_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      idx_in  = idx_ff;
      lead_in = lead_ff;

      if (advance) begin
         case (step_ff)
            lntf_pkg::STEP_DIGIT: begin
               lead_in = lead_now;
               if (idx_ff == '0) begin
                  step_in = lntf_pkg::STEP_NUM_TAB;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
            lntf_pkg::STEP_NUM_TAB:   step_in = skip(cur_ff, lntf_pkg::STEP_DOLLAR);
            lntf_pkg::STEP_DOLLAR:    step_in = skip(cur_ff, lntf_pkg::STEP_META_M);
            lntf_pkg::STEP_META_M:    step_in = lntf_pkg::STEP_META_DASH;
            lntf_pkg::STEP_META_DASH: step_in = skip(cur_ff, lntf_pkg::STEP_CARET);
            lntf_pkg::STEP_CARET:     step_in = lntf_pkg::STEP_CHAR;
            lntf_pkg::STEP_CHAR:      busy_in = 1'b0;
            default:                  busy_in = 1'b0;
         endcase
      end

      if (load) begin
         cur_in  = job_data;
         busy_in = 1'b1;
         step_in = skip(job_data, lntf_pkg::STEP_DIGIT);
         idx_in  = TOP_DIGIT;
         lead_in = 1'b1;
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = (step_ff == lntf_pkg::STEP_CHAR);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= lntf_pkg::STEP_CHAR;
         idx_ff       <= '0;
         lead_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         lead_ff      <= lead_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/line_numbering_text_filter.sv @@
// line_numbering_text_filter: top level, front classifier, job queue and back expander
// depends on lntf_pkg, lntf_front, lntf_queue, lntf_back
//
//  channel   handshake              payload
//  req       req_push / req_full    req_in_byte[7:0], req_file_start
//  rsp       rsp_pop / rsp_empty    rsp_out_byte[7:0], rsp_last_of_run
//  csr       csr_valid / csr_ready  csr_index[2:0], csr_wdata[7:0]
//
// the front takes one input transaction per cycle while the job queue has room
// the back emits one output byte per cycle while the output is popped or empty;
// an item's bytes come from its expansion (line number and tab, dollar, M- prefix, caret, byte)
// a squeezed newline leaves no job and never reaches the back
// reset is synchronous; csr_ready is always high
// a stalled result holds in the output register while the front keeps filling the queue
`default_nettype none

module line_numbering_text_filter (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_push,
   output logic                              req_full,
   input  wire  [7:0]                        req_in_byte,
   input  wire                               req_file_start,
   output logic                              rsp_empty,
   input  wire                               rsp_pop,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_of_run,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [lntf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [lntf_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic               q_push;
   lntf_pkg::job_type  q_push_data;
   logic               q_full;
   logic               q_pop;
   lntf_pkg::job_type  q_pop_data;
   logic               q_empty;

   // classifier and line state
   lntf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_in_byte    (req_in_byte),
      .req_file_start (req_file_start),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .job_push       (q_push),
      .job_data       (q_push_data),
      .job_full       (q_full)
   );

   // job queue
   lntf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   // byte expander
   lntf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_data        (q_pop_data),
      .job_empty       (q_empty),
      .job_pop         (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

@@ test/lntf_output_checker.sv @@
`timescale 1ns / 100ps
// lntf_output_checker: watches the req, rsp and csr channels of the text filter,
// expands each accepted input byte into its expected output bytes and compares them
// depends on lntf_pkg for widths and character codes
module lntf_output_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_push,
   input  wire                             req_full,
   input  wire [7:0]                       req_in_byte,
   input  wire                             req_file_start,
   input  wire                             rsp_empty,
   input  wire                             rsp_pop,
   input  wire [7:0]                       rsp_out_byte,
   input  wire                             rsp_last_of_run,
   input  wire                             csr_valid,
   input  wire                             csr_ready,
   input  wire [lntf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [lntf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              bytes_owed
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } out_beat_type;

   out_beat_type expected_bytes[$];

   // shadow of the filter's registers and line state
   logic [1:0]                 number_mode;
   logic                       squeeze_blank;
   logic                       show_ends;
   logic                       show_tabs;
   logic                       show_nonprinting;
   logic                       line_start;
   logic [1:0]                 blank_run;
   logic [lntf_pkg::BCD_W-1:0] shadow_number;
   int                         errors;

   // decimal counter step, holds at all nines
   function automatic logic [lntf_pkg::BCD_W-1:0] count_up(
      input logic [lntf_pkg::BCD_W-1:0] v);
      logic [lntf_pkg::BCD_W-1:0] r;
      r = v;
      if (v == {lntf_pkg::NUMBER_DIGITS{4'h9}}) return v;
      for (int i = 0; i < lntf_pkg::NUMBER_DIGITS; i++) begin
         if (r[4*i +: 4] < 4'd9) begin
            r[4*i +: 4] = r[4*i +: 4] + 4'd1;
            return r;
         end
         r[4*i +: 4] = 4'd0;
      end
      return r;
   endfunction

   // expected output bytes for one accepted input byte
   function automatic void expand_byte(input logic [7:0] raw, input logic fs);
      logic [7:0] burst[$];
      logic [7:0] ch;
      logic [3:0] d;
      logic       nl;
      logic       lead;
      ch = raw;
      nl = (raw == lntf_pkg::CH_NEWLINE);
      if (fs) begin
         line_start = 1'b1;
         blank_run = 2'd1;
      end
      // blank run tracking, and the squeezed newline that leaves nothing behind
      if (nl) begin
         if (squeeze_blank && blank_run >= 2'd2) return;
         if (blank_run < 2'd2) blank_run = blank_run + 2'd1;
      end else begin
         blank_run = 2'd0;
      end
      // line number column and tab; mode three behaves as non-blank numbering
      if (line_start && (number_mode == lntf_pkg::NUM_ALL || (number_mode[1] && !nl))) begin
         lead = 1'b1;
         for (int i = lntf_pkg::NUMBER_DIGITS - 1; i >= 0; i--) begin
            d = shadow_number[4*i +: 4];
            if (d > 4'd9) d = 4'd9;
            if (d != 4'd0 || i == 0) lead = 1'b0;
            burst.push_back(lead ? lntf_pkg::CH_SPACE : lntf_pkg::CH_ZERO + {4'd0, d});
         end
         burst.push_back(lntf_pkg::CH_TAB);
         shadow_number = count_up(shadow_number);
      end
      if (show_ends && nl) burst.push_back(lntf_pkg::CH_DOLLAR);
      if (show_tabs && ch == lntf_pkg::CH_TAB) begin
         burst.push_back(lntf_pkg::CH_CARET);
         ch = lntf_pkg::CH_I;
      end
      // meta prefix, then caret form for control bytes and delete
      if (show_nonprinting && ch != lntf_pkg::CH_TAB && ch != lntf_pkg::CH_NEWLINE) begin
         if (ch[7]) begin
            burst.push_back(lntf_pkg::CH_M);
            burst.push_back(lntf_pkg::CH_DASH);
         end
         ch[7] = 1'b0;
         if (ch < lntf_pkg::CH_CTRL_END) begin
            burst.push_back(lntf_pkg::CH_CARET);
            ch = ch + lntf_pkg::CH_CTRL_OFFSET;
         end else if (ch == lntf_pkg::CH_DEL) begin
            burst.push_back(lntf_pkg::CH_CARET);
            ch = lntf_pkg::CH_QUESTION;
         end
      end
      burst.push_back(ch);
      line_start = nl;
      for (int k = 0; k < burst.size(); k++) begin
         expected_bytes.push_back('{out_byte: burst[k], last_of_run: (k == burst.size() - 1)});
      end
   endfunction

   // output transaction first, then register write, then input transaction
   always @(posedge clock) begin
      out_beat_type exp_beat;
      if (reset) begin
         number_mode = lntf_pkg::NUM_NONE;
         squeeze_blank = 1'b0;
         show_ends = 1'b0;
         show_tabs = 1'b0;
         show_nonprinting = 1'b0;
         line_start = 1'b1;
         blank_run = 2'd1;
         shadow_number = {{(lntf_pkg::BCD_W-4){1'b0}}, 4'd1};
         errors = 0;
         expected_bytes.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               $error("output transaction with nothing expected: out_byte %h", rsp_out_byte);
               errors++;
            end else begin
               exp_beat = expected_bytes.pop_front();
               if (rsp_out_byte !== exp_beat.out_byte) begin
                  $error("out_byte: expected %h, got %h", exp_beat.out_byte, rsp_out_byte);
                  errors++;
               end
               if (rsp_last_of_run !== exp_beat.last_of_run) begin
                  $error("last_of_run: expected %b, got %b",
                         exp_beat.last_of_run, rsp_last_of_run);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lntf_pkg::CSR_NUMBER_MODE:      number_mode = csr_wdata[1:0];
               lntf_pkg::CSR_SQUEEZE_BLANK:    squeeze_blank = csr_wdata[0];
               lntf_pkg::CSR_SHOW_ENDS:        show_ends = csr_wdata[0];
               lntf_pkg::CSR_SHOW_TABS:        show_tabs = csr_wdata[0];
               lntf_pkg::CSR_SHOW_NONPRINTING: show_nonprinting = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_push && !req_full) expand_byte(req_in_byte, req_file_start);
      end
      mismatch_count <= errors;
      bytes_owed <= expected_bytes.size();
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// testbench: drives text bytes and register settings into the line numbering text filter
// depends on lntf_pkg, line_numbering_text_filter and lntf_output_checker
module testbench;

   localparam logic [1:0] NUM_NONBLANK = 2'd2;
   localparam logic [1:0] NUM_ALIAS = 2'd3;
   localparam logic [lntf_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 48;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 17;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_push = 1'b0;
   logic                             req_full;
   logic [7:0]                       req_in_byte = 8'h00;
   logic                             req_file_start = 1'b0;
   logic                             rsp_empty;
   logic                             rsp_pop = 1'b0;
   logic [7:0]                       rsp_out_byte;
   logic                             rsp_last_of_run;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [lntf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lntf_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   int                               mismatch_count;
   int                               bytes_owed;
   int                               idle_pct = 0;
   int                               stall_pct = 0;

   line_numbering_text_filter dut (.*);

   lntf_output_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // receiver stalls at random
   always @(posedge clock) rsp_pop <= ($urandom_range(99) >= stall_pct);

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // one input transaction, with a random gap ahead of it
   task automatic send_byte(input logic [7:0] b, input logic fs);
      if ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_push <= 1'b1;
      req_in_byte <= b;
      req_file_start <= fs;
      do @(posedge clock); while (req_full);
   endtask

   // wait for every expected byte, then let squeezed newlines drain
   task automatic drain_filter();
      req_push <= 1'b0;
      do @(posedge clock); while (bytes_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes the unused index and then all five registers, junk in the upper bits
   task automatic program_csr(input logic [1:0] mode, input logic sq, input logic en,
                              input logic tb, input logic np);
      logic [lntf_pkg::CSR_INDEX_W-1:0] idx[6];
      logic [lntf_pkg::CSR_DATA_W-1:0]  val[6];
      idx = '{CSR_UNUSED, lntf_pkg::CSR_NUMBER_MODE, lntf_pkg::CSR_SQUEEZE_BLANK,
              lntf_pkg::CSR_SHOW_ENDS, lntf_pkg::CSR_SHOW_TABS,
              lntf_pkg::CSR_SHOW_NONPRINTING};
      val = '{8'($urandom), {6'($urandom), mode}, {7'($urandom), sq},
              {7'($urandom), en}, {7'($urandom), tb}, {7'($urandom), np}};
      for (int k = 0; k < 6; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // mostly text with frequent newlines, some tabs and some arbitrary bytes
   function automatic logic [7:0] text_char();
      int r;
      r = $urandom_range(99);
      if (r < 30) return lntf_pkg::CH_NEWLINE;
      if (r < 38) return lntf_pkg::CH_TAB;
      if (r < 55) return 8'($urandom);
      return 8'($urandom_range(8'h7E, 8'h20));
   endfunction

   initial begin
      logic [1:0] mode;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: every escape at once, squeezing and numbering every line
      program_csr(lntf_pkg::NUM_ALL, 1'b1, 1'b1, 1'b1, 1'b1);
      send_byte(8'h41, 1'b1);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b0);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b0);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b0);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b0);
      send_byte(lntf_pkg::CH_TAB, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(lntf_pkg::CH_DEL, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h89, 1'b0);
      send_byte(8'h8A, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b0);
      drain_filter();

      // directed: mode three, plain output, blank lines at a file start
      program_csr(NUM_ALIAS, 1'b0, 1'b0, 1'b0, 1'b0);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b1);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b0);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b0);
      send_byte(lntf_pkg::CH_TAB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b0);
      send_byte(8'h7A, 1'b1);
      send_byte(lntf_pkg::CH_NEWLINE, 1'b0);
      drain_filter();

      // random phases: settings and idling change between them
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: program_csr(lntf_pkg::NUM_NONE, 1'b0, 1'b0, 1'b0, 1'b0);
            1: program_csr(NUM_NONBLANK, 1'b1, 1'b1, 1'b1, 1'b1);
            2: program_csr(lntf_pkg::NUM_ALL, 1'b1, 1'b0, 1'b0, 1'b0);
            default: begin
               mode = 2'($urandom);
               program_csr(mode, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            end
         endcase
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 72; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 72; end
            default: begin idle_pct = 20; stall_pct <= 20; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_byte(text_char(), ($urandom_range(19) == 0));
         end
         drain_filter();
      end

      if (bytes_owed != 0) $error("%0d expected output bytes never arrived", bytes_owed);
      if (mismatch_count == 0 && bytes_owed == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/lntf_pkg.sv
hw/rtl/lntf_front.sv
hw/rtl/lntf_queue.sv
hw/rtl/lntf_back.sv
hw/rtl/line_numbering_text_filter.sv
test/lntf_output_checker.sv
test/testbench.sv
